### rtl/avr_pkg.sv
// Shared constants, types and configuration codes for the averaged voltage reporter.
package avr_pkg;

    // Averaging window and sample format.
    localparam int WINDOW_LEN = 16;
    localparam int SAMPLE_W   = 10;
    localparam int SAMPLE_MAX = 1023;
    localparam int SUM_W      = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);
    localparam int POS_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    // Configuration and result widths.
    localparam int SCALE_W    = 32;
    localparam int THRESH_W   = 16;
    localparam int PERIOD_W   = 8;
    localparam int ID_W       = 8;
    localparam int VOLT_W     = 32;
    localparam int FRAC_SHIFT = 16;
    localparam int PROD_W     = SUM_W + SCALE_W;
    localparam int WIDE_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration reset values.
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = '0;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1311;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;
    localparam logic [ID_W-1:0]     ID_RESET     = '0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE     = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_PERIOD    = 2'd2,
        CFG_DEVICE_ID = 2'd3
    } cfg_reg_t;

    // Word passed from the window stage to the scaling stage.
    typedef struct packed {
        logic             check;
        logic [SUM_W-1:0] sum;
    } avr_sum_t;

    // Word passed from the scaling stage to the report stage.
    typedef struct packed {
        logic              check;
        logic [VOLT_W-1:0] volts;
    } avr_volt_t;

endpackage

### rtl/avr_window.sv
// Sample ring, running window sum and decimation counter (first pipeline stage).
module avr_window
    import avr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] adc_sample,
    input  logic [PERIOD_W-1:0] send_period,
    output logic                sum_valid,
    input  logic                sum_ready,
    output avr_sum_t            sum_word
);

    logic [SAMPLE_W-1:0] ring_reg [WINDOW_LEN];
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [PERIOD_W-1:0] count_reg;
    logic [PERIOD_W-1:0] count_next;
    logic                check;
    logic                accept;
    logic                valid_reg;
    avr_sum_t            word_reg;

    // The stage takes a new word whenever its register is empty or drains.
    assign in_ready = !valid_reg || sum_ready;
    assign accept   = in_valid && in_ready;

    // Replace the oldest sample in the running sum and advance the ring.
    always_comb
    begin
        sum_next = sum_reg - SUM_W'(ring_reg[pos_reg]) + SUM_W'(adc_sample);
        if (pos_reg == POS_W'(WINDOW_LEN - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // A report check is due once the counter has reached the period.
    always_comb
    begin
        check = (count_reg >= send_period);
        if (check)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // Ring storage, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            ring_reg[pos_reg] <= adc_sample;
        end
    end

    // Window state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // Stage output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (sum_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.check <= check;
            word_reg.sum   <= sum_next;
        end
    end

    assign sum_valid = valid_reg;
    assign sum_word  = word_reg;

endmodule

### rtl/avr_scale.sv
// Scaling of the window sum to Q16.16 volts with saturation (second pipeline stage).
module avr_scale
    import avr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sum_valid,
    output logic               sum_ready,
    input  avr_sum_t           sum_word,
    input  logic [SCALE_W-1:0] scale_factor,
    output logic               volt_valid,
    input  logic               volt_ready,
    output avr_volt_t          volt_word
);

    logic [PROD_W-1:0] product;
    logic [WIDE_W-1:0] shifted;
    logic [VOLT_W-1:0] volts;
    logic              accept;
    logic              valid_reg;
    avr_volt_t         word_reg;

    assign sum_ready = !valid_reg || volt_ready;
    assign accept    = sum_valid && sum_ready;

    // One multiply, truncate the low fraction bits, then clamp to 32 bits.
    always_comb
    begin
        product = PROD_W'(sum_word.sum) * PROD_W'(scale_factor);
        shifted = WIDE_W'(product >> FRAC_SHIFT);
        if (|shifted[WIDE_W-1:VOLT_W])
        begin
            volts = '1;
        end
        else
        begin
            volts = shifted[VOLT_W-1:0];
        end
    end

    // Stage output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (volt_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.check <= sum_word.check;
            word_reg.volts <= volts;
        end
    end

    assign volt_valid = valid_reg;
    assign volt_word  = word_reg;

endmodule

### rtl/avr_report.sv
// Deadband compare against the last reported voltage and the result register.
module avr_report
    import avr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                volt_valid,
    output logic                volt_ready,
    input  avr_volt_t           volt_word,
    input  logic [THRESH_W-1:0] report_threshold,
    input  logic [ID_W-1:0]     device_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ID_W-1:0]     report_id,
    output logic [VOLT_W-1:0]   voltage_q16
);

    logic [VOLT_W-1:0] last_reg;
    logic [VOLT_W-1:0] diff;
    logic              hit;
    logic              accept;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ID_W-1:0]   id_reg;
    logic [VOLT_W-1:0] volts_reg;

    assign volt_ready = !out_valid_reg || out_ready;
    assign accept     = volt_valid && volt_ready;

    // Absolute change since the last report, strictly above the threshold.
    always_comb
    begin
        if (last_reg > volt_word.volts)
        begin
            diff = last_reg - volt_word.volts;
        end
        else
        begin
            diff = volt_word.volts - last_reg;
        end
        hit = volt_word.check && (diff > VOLT_W'(report_threshold));
    end

    // The result word stays until taken; a new report may load as it leaves.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (accept && hit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept && hit)
            begin
                last_reg <= volt_word.volts;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hit)
        begin
            id_reg    <= device_id;
            volts_reg <= volt_word.volts;
        end
    end

    assign out_valid   = out_valid_reg;
    assign report_id   = id_reg;
    assign voltage_q16 = volts_reg;

endmodule

### rtl/averaged_voltage_reporter_core.sv
// Top level of the averaged voltage reporter: configuration registers and pipeline.
//
// The block takes one 10-bit converter sample per clock while in_ready is high
// and keeps a boxcar average over the last 16 samples (ring cleared at reset).
// The window sum is multiplied by scale_factor (2^-32 V per count), truncated
// to unsigned Q16.16 volts and clamped to 32 bits. Every send_period plus one
// samples the voltage is compared with the last reported value, and a word with
// device_id and the voltage is emitted when the change is strictly greater than
// report_threshold. Throughput is one sample per cycle when the output does not
// stall. A sample passes through the window stage register, the multiply stage
// register (one 14 by 32 bit product) and the compare stage result register.
// A stalled output holds the whole pipeline.
// Configuration registers are written with cfg_write, cfg_index and cfg_data
// and must only change while idle.
module averaged_voltage_reporter_core
    import avr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SAMPLE_W-1:0]   adc_sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ID_W-1:0]       report_id,
    output logic [VOLT_W-1:0]     voltage_q16
);

    logic [SCALE_W-1:0]  scale_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [ID_W-1:0]     id_reg;

    logic      sum_valid;
    logic      sum_ready;
    avr_sum_t  sum_word;
    logic      volt_valid;
    logic      volt_ready;
    avr_volt_t volt_word;

    // Configuration registers; bits above each register's width are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RESET;
            thresh_reg <= THRESH_RESET;
            period_reg <= PERIOD_RESET;
            id_reg     <= ID_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SCALE:     scale_reg  <= cfg_data[SCALE_W-1:0];
                CFG_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                CFG_PERIOD:    period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_DEVICE_ID: id_reg     <= cfg_data[ID_W-1:0];
                default:       scale_reg  <= scale_reg;
            endcase
        end
    end

    // Window stage.
    avr_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .adc_sample  (adc_sample),
        .send_period (period_reg),
        .sum_valid   (sum_valid),
        .sum_ready   (sum_ready),
        .sum_word    (sum_word)
    );

    // Scaling stage.
    avr_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .sum_valid    (sum_valid),
        .sum_ready    (sum_ready),
        .sum_word     (sum_word),
        .scale_factor (scale_reg),
        .volt_valid   (volt_valid),
        .volt_ready   (volt_ready),
        .volt_word    (volt_word)
    );

    // Report stage.
    avr_report u_report (
        .clk              (clk),
        .rst_n            (rst_n),
        .volt_valid       (volt_valid),
        .volt_ready       (volt_ready),
        .volt_word        (volt_word),
        .report_threshold (thresh_reg),
        .device_id        (id_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .report_id        (report_id),
        .voltage_q16      (voltage_q16)
    );

    // An empty window stage must always be able to take a sample.
    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !sum_valid |-> in_ready
    ) else $error("input stalled with an empty window stage");

    // A stalled window word must be held for the scaling stage.
    a_sum_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        sum_valid && !sum_ready |=> sum_valid && $stable(sum_word)
    ) else $error("window word lost or changed while stalled");

    // A stalled voltage word must be held for the report stage.
    a_volt_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        volt_valid && !volt_ready |=> volt_valid && $stable(volt_word)
    ) else $error("voltage word lost or changed while stalled");

endmodule
